// ===== rtl/fat12_pkg.sv =====
// ----------------------------------------------------------------------------
// FAT12 allocator package
// Beat types, memory request type and fixed constants shared by the block.
// ----------------------------------------------------------------------------
package fat12_pkg;

  localparam int BYTE_ADDR_W = 13;
  localparam int CLUSTER_W   = 12;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_ALLOC = 2'd2;

  localparam logic [CLUSTER_W-1:0] END_MARK      = 12'hFFF;
  localparam logic [CLUSTER_W-1:0] FIRST_CLUSTER = 12'd2;
  localparam logic [7:0]           LO_NIB        = 8'h0F;
  localparam logic [7:0]           HI_NIB        = 8'hF0;

  typedef struct packed {
    logic [1:0]             action;
    logic [BYTE_ADDR_W-1:0] byte_offset;
    logic [7:0]             byte_value;
    logic                   last_sector;
  } in_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster;
    logic [7:0]           read_byte;
    logic                 chain_first;
    logic                 table_full;
  } out_t;

  typedef struct packed {
    logic                   we;
    logic [BYTE_ADDR_W-1:0] addr;
    logic [7:0]             wdata;
  } mem_req_t;

endpackage

// ===== rtl/fat12_mem.sv =====
// ----------------------------------------------------------------------------
// FAT12 table byte memory
// Single-port synchronous byte RAM, registered read.
// ----------------------------------------------------------------------------
module fat12_mem #(
  parameter int DEPTH = 6144
) (
  input  logic               clk,
  input  fat12_pkg::mem_req_t req,
  output logic [7:0]         rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.addr[AW-1:0]] <= req.wdata;
    end
    rdata_r <= mem_r[req.addr[AW-1:0]];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fat12_seq.sv =====
// ----------------------------------------------------------------------------
// FAT12 allocator sequencer
// Byte access, first-fit scan and read-modify-write of packed 12-bit entries.
// ----------------------------------------------------------------------------
module fat12_seq #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fat12_pkg::in_t      in_data,
  output logic                res_valid,
  input  logic                res_ready,
  output fat12_pkg::out_t     res_data,
  output fat12_pkg::mem_req_t mem_req,
  input  logic [7:0]          mem_rdata
);

  localparam int TABLE_BYTES = (3 * TABLE_ENTRIES + 1) / 2;
  localparam int AW = fat12_pkg::BYTE_ADDR_W;
  localparam int CW = fat12_pkg::CLUSTER_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WR   = 4'd1;
  localparam logic [3:0] S_RD0  = 4'd2;
  localparam logic [3:0] S_RD1  = 4'd3;
  localparam logic [3:0] S_SC0  = 4'd4;
  localparam logic [3:0] S_SC1  = 4'd5;
  localparam logic [3:0] S_SC2  = 4'd6;
  localparam logic [3:0] S_P0   = 4'd7;
  localparam logic [3:0] S_P1   = 4'd8;
  localparam logic [3:0] S_P2   = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]           state_r, state_nxt;
  fat12_pkg::in_t       item_r, item_nxt;
  logic [AW-1:0]        scan_r, scan_nxt;
  logic [7:0]           lo_r, lo_nxt;
  logic [CW-1:0]        put_idx_r, put_idx_nxt;
  logic [CW-1:0]        put_val_r, put_val_nxt;
  logic [7:0]           sh_r, sh_nxt;
  logic                 pend_end_r, pend_end_nxt;
  logic                 chain_open_r, chain_open_nxt;
  logic [CW-1:0]        prev_r, prev_nxt;
  fat12_pkg::out_t      res_r, res_nxt;

  logic [AW-1:0] scan_b;
  logic [AW-1:0] put_b;
  logic          in_range;
  logic          scan_end;
  logic [CW-1:0] scan_entry;

  assign scan_b     = scan_r + {1'b0, scan_r[AW-1:1]};
  assign put_b      = {1'b0, put_idx_r} + {2'b00, put_idx_r[CW-1:1]};
  assign in_range   = item_r.byte_offset < AW'(TABLE_BYTES);
  assign scan_end   = scan_r >= AW'(TABLE_ENTRIES);
  assign scan_entry = scan_r[0] ? {mem_rdata, lo_r[7:4]} : {mem_rdata[3:0], lo_r};

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_data  = res_r;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    scan_nxt       = scan_r;
    lo_nxt         = lo_r;
    put_idx_nxt    = put_idx_r;
    put_val_nxt    = put_val_r;
    sh_nxt         = sh_r;
    pend_end_nxt   = pend_end_r;
    chain_open_nxt = chain_open_r;
    prev_nxt       = prev_r;
    res_nxt        = res_r;
    mem_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          res_nxt  = '0;
          if (chain_open_r) begin
            scan_nxt = {1'b0, prev_r} + AW'(1);
          end else begin
            scan_nxt = {1'b0, fat12_pkg::FIRST_CLUSTER};
          end
          unique case (in_data.action)
            fat12_pkg::ACT_WRITE: state_nxt = S_WR;
            fat12_pkg::ACT_READ:  state_nxt = S_RD0;
            fat12_pkg::ACT_ALLOC: state_nxt = S_SC0;
            default:              state_nxt = S_DONE;
          endcase
        end
      end
      S_WR: begin
        mem_req.we    = in_range;
        mem_req.addr  = item_r.byte_offset;
        mem_req.wdata = item_r.byte_value;
        state_nxt     = S_DONE;
      end
      S_RD0: begin
        mem_req.addr = item_r.byte_offset;
        state_nxt    = S_RD1;
      end
      S_RD1: begin
        res_nxt.read_byte = in_range ? mem_rdata : 8'd0;
        state_nxt         = S_DONE;
      end
      S_SC0: begin
        if (scan_end) begin
          res_nxt.table_full = 1'b1;
          chain_open_nxt     = 1'b0;
          prev_nxt           = '0;
          pend_end_nxt       = 1'b0;
          if (chain_open_r) begin
            put_idx_nxt = prev_r;
            put_val_nxt = fat12_pkg::END_MARK;
            state_nxt   = S_P0;
          end else begin
            state_nxt   = S_DONE;
          end
        end else begin
          mem_req.addr = scan_b;
          state_nxt    = S_SC1;
        end
      end
      S_SC1: begin
        lo_nxt       = mem_rdata;
        mem_req.addr = scan_b + AW'(1);
        state_nxt    = S_SC2;
      end
      S_SC2: begin
        if (scan_entry == '0) begin
          res_nxt.cluster     = scan_r[CW-1:0];
          res_nxt.chain_first = !chain_open_r;
          if (item_r.last_sector) begin
            chain_open_nxt = 1'b0;
            prev_nxt       = '0;
          end else begin
            chain_open_nxt = 1'b1;
            prev_nxt       = scan_r[CW-1:0];
          end
          if (chain_open_r) begin
            put_idx_nxt  = prev_r;
            put_val_nxt  = scan_r[CW-1:0];
            pend_end_nxt = item_r.last_sector;
            state_nxt    = S_P0;
          end else if (item_r.last_sector) begin
            put_idx_nxt  = scan_r[CW-1:0];
            put_val_nxt  = fat12_pkg::END_MARK;
            pend_end_nxt = 1'b0;
            state_nxt    = S_P0;
          end else begin
            state_nxt    = S_DONE;
          end
        end else begin
          scan_nxt  = scan_r + AW'(1);
          state_nxt = S_SC0;
        end
      end
      S_P0: begin
        // fetch the byte shared with the neighbor entry
        mem_req.addr = put_idx_r[0] ? put_b : put_b + AW'(1);
        state_nxt    = S_P1;
      end
      S_P1: begin
        sh_nxt       = mem_rdata;
        mem_req.we   = 1'b1;
        mem_req.addr = put_b;
        if (put_idx_r[0]) begin
          mem_req.wdata = (mem_rdata & fat12_pkg::LO_NIB) | {put_val_r[3:0], 4'b0000};
        end else begin
          mem_req.wdata = put_val_r[7:0];
        end
        state_nxt = S_P2;
      end
      S_P2: begin
        mem_req.we   = 1'b1;
        mem_req.addr = put_b + AW'(1);
        if (put_idx_r[0]) begin
          mem_req.wdata = put_val_r[CW-1:4];
        end else begin
          mem_req.wdata = (sh_r & fat12_pkg::HI_NIB) | {4'b0000, put_val_r[CW-1:8]};
        end
        if (pend_end_r) begin
          put_idx_nxt  = scan_r[CW-1:0];
          put_val_nxt  = fat12_pkg::END_MARK;
          pend_end_nxt = 1'b0;
          state_nxt    = S_P0;
        end else begin
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_end_r   <= 1'b0;
      chain_open_r <= 1'b0;
      prev_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      pend_end_r   <= pend_end_nxt;
      chain_open_r <= chain_open_nxt;
      prev_r       <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    scan_r    <= scan_nxt;
    lo_r      <= lo_nxt;
    put_idx_r <= put_idx_nxt;
    put_val_r <= put_val_nxt;
    sh_r      <= sh_nxt;
    res_r     <= res_nxt;
  end

endmodule

// ===== rtl/fat12_cluster_chain_allocator.sv =====
// ----------------------------------------------------------------------------
// FAT12 cluster chain allocator
// Packed FAT12 table with byte access and first-fit cluster allocation.
// An allocate scans entries first-fit, then updates up to two entries (link from the
//   chain tail, end mark) by read-modify-write before the result beat.
// One item at a time; the next beat is taken once the result sits in the
//   output register. Scan speed is set by the single table memory port.
// Reset clears sequencer, chain and output-valid state; table bytes are undefined until written.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_allocator #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  fat12_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output fat12_pkg::out_t out_data
);

  localparam int TABLE_BYTES = (3 * TABLE_ENTRIES + 1) / 2;

  fat12_pkg::mem_req_t mem_req;
  logic [7:0]          mem_rdata;
  logic                res_valid;
  logic                res_ready;
  fat12_pkg::out_t     res_data;

  logic                out_valid_r;
  fat12_pkg::out_t     out_data_r;

  fat12_mem #(
    .DEPTH (TABLE_BYTES)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  fat12_seq #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> !in_ready)
    else $error("table write outside item processing");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while item in flight");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result dropped while output register full");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.table_full |->
      out_data_r.cluster == '0 && !out_data_r.chain_first)
    else $error("table full beat carries a cluster");

endmodule

// ===== verif/fat12_cluster_chain_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT12 cluster chain allocator testbench
// Loads the low part of the packed table through the byte port, runs a short
// scripted sequence, then random file chains of allocate beats mixed with
// table writes and reads. An allocate whose scan would reach unloaded bytes
// goes out as a load of the next table byte instead.
// Every result beat is checked against a shadow table and chain tracker, or the scripted reply for typed rows.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_allocator_tb;

  localparam int         N_ENTRIES    = 4096;
  localparam int         N_BYTES      = (3 * N_ENTRIES + 1) / 2;
  localparam int         OFS_W        = fat12_pkg::BYTE_ADDR_W;
  localparam int         CL_W         = fat12_pkg::CLUSTER_W;
  localparam int         PREFIX_BYTES = 192;
  localparam int         RAND_BEATS   = 936;
  localparam int         QUIET_BEATS  = 100;
  localparam logic [1:0] ACT_UNUSED   = 2'd3;

  typedef struct {
    fat12_pkg::in_t  beat;
    bit              typed;
    fat12_pkg::out_t reply;
  } script_row_t;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  fat12_pkg::in_t  in_data;
  logic            out_valid;
  logic            out_ready;
  fat12_pkg::out_t out_data;

  logic [7:0]      fat_shadow [N_BYTES];
  bit              fat_written [N_BYTES];
  int unsigned     next_fill;
  logic            chain_live;
  logic [CL_W-1:0] chain_tail;
  fat12_pkg::out_t replies_due [$];
  fat12_pkg::out_t due_reply;
  script_row_t     script [$];
  int              mismatches;
  bit              gaps_on;

  fat12_cluster_chain_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] shadow_byte(int unsigned idx);
    return (idx < N_BYTES) ? fat_shadow[idx] : 8'h00;
  endfunction

  function automatic logic [CL_W-1:0] entry_value(int unsigned n);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = fat_shadow[3 * n / 2];
    hi = fat_shadow[3 * n / 2 + 1];
    if (n % 2 == 0) return {hi[3:0], lo};
    return {hi, lo[7:4]};
  endfunction

  // neighbor entry keeps its half of the shared byte
  function automatic void entry_store(int unsigned n, logic [CL_W-1:0] v);
    int unsigned b;
    b = 3 * n / 2;
    if (n % 2 == 0) begin
      fat_shadow[b]     = v[7:0];
      fat_shadow[b + 1] = (fat_shadow[b + 1] & fat12_pkg::HI_NIB) | {4'h0, v[11:8]};
    end else begin
      fat_shadow[b]     = (fat_shadow[b] & fat12_pkg::LO_NIB) | {v[3:0], 4'h0};
      fat_shadow[b + 1] = v[11:4];
    end
  endfunction

  // the next allocate only touches loaded bytes
  function automatic bit scan_safe();
    int unsigned n;
    int unsigned b;
    n = chain_live ? int'(chain_tail) + 1 : int'(fat12_pkg::FIRST_CLUSTER);
    while (n < N_ENTRIES) begin
      b = 3 * n / 2;
      if (!fat_written[b] || !fat_written[b + 1]) return 1'b0;
      if (entry_value(n) == '0) return 1'b1;
      n++;
    end
    return 1'b1;
  endfunction

  function automatic fat12_pkg::out_t fat_response(fat12_pkg::in_t beat);
    fat12_pkg::out_t r;
    int unsigned     n;
    bit              hit;
    r   = '0;
    hit = 1'b0;
    case (beat.action)
      fat12_pkg::ACT_WRITE: begin
        if (beat.byte_offset < N_BYTES) fat_shadow[beat.byte_offset] = beat.byte_value;
      end
      fat12_pkg::ACT_READ: begin
        r.read_byte = shadow_byte(beat.byte_offset);
      end
      fat12_pkg::ACT_ALLOC: begin
        n = chain_live ? int'(chain_tail) + 1 : int'(fat12_pkg::FIRST_CLUSTER);
        while (!hit && n < N_ENTRIES) begin
          if (entry_value(n) == '0) hit = 1'b1;
          else n++;
        end
        if (hit) begin
          if (chain_live) entry_store(chain_tail, n[CL_W-1:0]);
          else r.chain_first = 1'b1;
          r.cluster = n[CL_W-1:0];
          if (beat.last_sector) begin
            entry_store(n, fat12_pkg::END_MARK);
            chain_live = 1'b0;
            chain_tail = '0;
          end else begin
            chain_live = 1'b1;
            chain_tail = n[CL_W-1:0];
          end
        end else begin
          r.table_full = 1'b1;
          if (chain_live) entry_store(chain_tail, fat12_pkg::END_MARK);
          chain_live = 1'b0;
          chain_tail = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_row(logic [1:0] act, int unsigned off, logic [7:0] val,
                                  logic last, bit typed, logic [7:0] rbyte);
    script_row_t row;
    row.beat  = '{action: act, byte_offset: off[OFS_W-1:0], byte_value: val,
                  last_sector: last};
    row.typed = typed;
    row.reply = '{cluster: '0, read_byte: rbyte, chain_first: 1'b0, table_full: 1'b0};
    script.push_back(row);
  endfunction

  // mostly file chains, table traffic stays inside the loaded bytes apart from writes and reads past the table
  function automatic fat12_pkg::in_t random_beat();
    fat12_pkg::in_t b;
    int unsigned    roll;
    roll          = $urandom_range(0, 99);
    b.action      = fat12_pkg::ACT_ALLOC;
    b.byte_offset = OFS_W'($urandom_range(0, 8191));
    b.byte_value  = 8'($urandom_range(0, 255));
    b.last_sector = ($urandom_range(0, 3) == 0);
    if (roll >= 50 && roll < 72) begin
      b.action      = fat12_pkg::ACT_WRITE;
      b.byte_offset = OFS_W'($urandom_range(0, next_fill));
      if ($urandom_range(0, 4) < 3) b.byte_value = 8'h00;
    end else if (roll >= 72 && roll < 94) begin
      b.action      = fat12_pkg::ACT_READ;
      b.byte_offset = OFS_W'($urandom_range(0, next_fill - 1));
    end else if (roll >= 94 && roll < 97) begin
      b.action = ACT_UNUSED;
    end else if (roll >= 97) begin
      b.action      = ($urandom_range(0, 1) == 0) ? fat12_pkg::ACT_WRITE
                                                  : fat12_pkg::ACT_READ;
      b.byte_offset = OFS_W'($urandom_range(N_BYTES, 8191));
    end
    return b;
  endfunction

  task automatic send_beat(fat12_pkg::in_t beat, bit typed, fat12_pkg::out_t reply);
    fat12_pkg::in_t  sent;
    fat12_pkg::out_t guess;
    sent = beat;
    if (!typed && sent.action == fat12_pkg::ACT_ALLOC && !scan_safe()) begin
      sent.action      = fat12_pkg::ACT_WRITE;
      sent.byte_offset = OFS_W'(next_fill);
      sent.byte_value  = 8'h00;
      sent.last_sector = 1'b0;
    end
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= sent;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = fat_response(sent);
    if (sent.action == fat12_pkg::ACT_WRITE && sent.byte_offset < N_BYTES) begin
      fat_written[sent.byte_offset] = 1'b1;
      while (next_fill < N_BYTES && fat_written[next_fill]) next_fill++;
    end
    replies_due.push_back(typed ? reply : guess);
  endtask

  task automatic check_field(string what, logic [CL_W-1:0] want, logic [CL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  initial begin : ready_drive
    int unsigned hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        $display("%0t: result beat with nothing due: expected none, got %p",
                 $time, out_data);
        mismatches++;
      end else begin
        due_reply = replies_due.pop_front();
        check_field("cluster", due_reply.cluster, out_data.cluster);
        check_field("read_byte", CL_W'(due_reply.read_byte), CL_W'(out_data.read_byte));
        check_field("chain_first", CL_W'(due_reply.chain_first),
                    CL_W'(out_data.chain_first));
        check_field("table_full", CL_W'(due_reply.table_full),
                    CL_W'(out_data.table_full));
      end
    end
  end

  initial begin
    int unsigned    k;
    fat12_pkg::in_t b;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    chain_live = 1'b0;
    chain_tail = '0;
    next_fill  = 0;
    mismatches = 0;
    gaps_on    = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // table bytes are undefined until written
    for (k = 0; k < PREFIX_BYTES; k++) begin
      b.action      = fat12_pkg::ACT_WRITE;
      b.byte_offset = k[OFS_W-1:0];
      b.byte_value  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      b.last_sector = 1'($urandom_range(0, 1));
      send_beat(b, 1'b0, '0);
    end

    add_row(fat12_pkg::ACT_WRITE, 0,           8'hFF, 1'b0, 1'b1, 8'h00);
    add_row(fat12_pkg::ACT_READ,  0,           8'h00, 1'b0, 1'b1, 8'hFF);
    add_row(fat12_pkg::ACT_WRITE, N_BYTES - 1, 8'h00, 1'b1, 1'b1, 8'h00);
    add_row(fat12_pkg::ACT_READ,  N_BYTES - 1, 8'hFF, 1'b1, 1'b1, 8'h00);
    add_row(fat12_pkg::ACT_WRITE, 8191,        8'hFF, 1'b1, 1'b1, 8'h00);
    add_row(fat12_pkg::ACT_READ,  8191,        8'h00, 1'b0, 1'b1, 8'h00);
    add_row(fat12_pkg::ACT_READ,  N_BYTES,     8'h00, 1'b0, 1'b1, 8'h00);
    add_row(ACT_UNUSED,           8191,        8'hFF, 1'b1, 1'b1, 8'h00);
    add_row(ACT_UNUSED,           0,           8'h00, 1'b0, 1'b1, 8'h00);
    add_row(fat12_pkg::ACT_ALLOC, 0,           8'h00, 1'b0, 1'b0, 8'h00);
    add_row(fat12_pkg::ACT_ALLOC, 0,           8'h00, 1'b0, 1'b0, 8'h00);
    add_row(fat12_pkg::ACT_ALLOC, 0,           8'h00, 1'b1, 1'b0, 8'h00);
    add_row(fat12_pkg::ACT_ALLOC, 0,           8'h00, 1'b1, 1'b0, 8'h00);
    add_row(fat12_pkg::ACT_READ,  3,           8'h00, 1'b0, 1'b0, 8'h00);
    add_row(fat12_pkg::ACT_READ,  4,           8'h00, 1'b0, 1'b0, 8'h00);
    add_row(fat12_pkg::ACT_READ,  5,           8'h00, 1'b0, 1'b0, 8'h00);
    add_row(fat12_pkg::ACT_WRITE, 4,           8'h00, 1'b0, 1'b1, 8'h00);
    add_row(fat12_pkg::ACT_WRITE, 3,           8'h00, 1'b0, 1'b1, 8'h00);
    add_row(fat12_pkg::ACT_ALLOC, 0,           8'h00, 1'b0, 1'b0, 8'h00);
    add_row(fat12_pkg::ACT_ALLOC, 0,           8'h00, 1'b1, 1'b0, 8'h00);
    add_row(fat12_pkg::ACT_READ,  3,           8'h00, 1'b0, 1'b0, 8'h00);
    add_row(fat12_pkg::ACT_READ,  4,           8'h00, 1'b0, 1'b0, 8'h00);
    foreach (script[i]) send_beat(script[i].beat, script[i].typed, script[i].reply);

    for (k = 0; k < RAND_BEATS; k++) begin
      if (k % 100 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (k >= RAND_BEATS - QUIET_BEATS) gaps_on = 1'b0;
      send_beat(random_beat(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("fat12_cluster_chain_allocator_tb: PASS");
    end else begin
      $display("fat12_cluster_chain_allocator_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("fat12_cluster_chain_allocator_tb: FAIL");
    $finish;
  end

endmodule
